/* hdl/region_fix_after_replace_macros.svh */
// Assertion macros shared by the interval rewrite RTL.
`ifndef REGION_FIX_AFTER_REPLACE_MACROS_SVH
`define REGION_FIX_AFTER_REPLACE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define RFAR_ASSERT_IMP(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) \
		else $error("implication check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define RFAR_ASSERT_NXT(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) \
		else $error("next-cycle check failed");

`endif

/* hdl/rfar_pkg.sv */
// Types, codes and helpers for the interval rewrite block.
`timescale 1ns / 1ps
`default_nettype none

package rfar_pkg;

	// Signed width that holds any sum or difference of two 32-bit positions.
	localparam int ArithW = 35;

	typedef enum logic [1:0] {
		STRAT_REMOVE       = 2'd0,
		STRAT_RESIZE       = 2'd1,
		STRAT_SPLIT_JOINED = 2'd2,
		STRAT_SPLIT_NEW    = 2'd3
	} strategy_t;

	typedef enum logic [1:0] {
		REG_CUT_START     = 2'd0,
		REG_CUT_LENGTH    = 2'd1,
		REG_INSERT_LENGTH = 2'd2,
		REG_STRATEGY      = 2'd3
	} reg_index_t;

	typedef struct packed {
		logic [31:0] cut_start;
		logic [31:0] cut_length;
		logic [31:0] insert_length;
		strategy_t   strategy;
	} cfg_t;

	typedef struct packed {
		logic [31:0] start;
		logic [31:0] length;
		logic        to_new;
		logic        ovf;
	} res_t;

	typedef struct packed {
		logic [1:0] count;
		res_t       first;
		res_t       second;
	} fix_out_t;

	// Negative or above pmax saturates to pmax; returns {overflow, value}.
	function automatic logic [32:0] sat_pos(input logic signed [ArithW-1:0] v,
		input logic [32:0] pmax);
		logic [ArithW-1:0] pm;
		logic              hit;
		pm  = {2'b00, pmax};
		hit = v[ArithW-1] || (ArithW'(v) > pm);
		if (hit) begin
			sat_pos = {1'b1, pmax[31:0]};
		end else begin
			sat_pos = {1'b0, v[31:0]};
		end
	endfunction

endpackage

`default_nettype wire

/* hdl/rfar_if.sv */
// Valid/ready channel interfaces: input interval, result interval, register write.
`timescale 1ns / 1ps
`default_nettype none

interface rfar_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] region_start;
	logic [31:0] region_length;

	modport source (output valid, output region_start, output region_length, input ready);
	modport sink (input valid, input region_start, input region_length, output ready);
endinterface

interface rfar_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] out_start;
	logic [31:0] out_length;
	logic        to_new_annotation;
	logic        last_of_run;
	logic        overflow;

	modport source (output valid, output out_start, output out_length,
		output to_new_annotation, output last_of_run, output overflow, input ready);
	modport sink (input valid, input out_start, input out_length,
		input to_new_annotation, input last_of_run, input overflow, output ready);
endinterface

interface rfar_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [31:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* hdl/rfar_fix.sv */
// Combinational rewrite of one interval against the replaced span.
`timescale 1ns / 1ps
`default_nettype none

module rfar_fix #(
	parameter int POS_WIDTH = 32
) (
	input  var rfar_pkg::cfg_t     cfg,
	input  var logic [31:0]        rs_in,
	input  var logic [31:0]        rl_in,
	output var rfar_pkg::fix_out_t fix
);

	localparam int VW = (POS_WIDTH < 32) ? POS_WIDTH : 32;
	localparam logic [32:0] PosMax = (33'd1 << VW) - 33'd1;
	localparam int AW = rfar_pkg::ArithW;

	logic signed [AW-1:0] cs, cl, il, rs, rl, ce, d, re, is_pos, ie_pos;
	logic signed [AW-1:0] a_s, a_l, b_s, b_l;
	logic                 b_new;
	logic [1:0]           cnt;
	logic                 has_left, has_right;
	logic [32:0]          sa_s, sa_l, sb_s, sb_l;

	assign cs = $signed({3'b000, cfg.cut_start});
	assign cl = $signed({3'b000, cfg.cut_length});
	assign il = $signed({3'b000, cfg.insert_length});
	assign rs = $signed({3'b000, rs_in});
	assign rl = $signed({3'b000, rl_in});
	assign ce = cs + cl;
	assign d  = il - cl;
	assign re = rs + rl;

	// Overlap window for the split strategies
	assign is_pos    = (rs > cs) ? rs : cs;
	assign ie_pos    = (re < ce) ? re : ce;
	assign has_left  = rs < is_pos;
	assign has_right = re > ie_pos;

	always_comb begin
		cnt   = 2'd0;
		a_s   = rs;
		a_l   = rl;
		b_s   = ie_pos + d;
		b_l   = re - ie_pos;
		b_new = has_left && (cfg.strategy == rfar_pkg::STRAT_SPLIT_NEW);
		priority if (cfg.strategy == rfar_pkg::STRAT_RESIZE
			&& cfg.insert_length == cfg.cut_length) begin
			cnt = 2'd1;
		end else if (re <= cs) begin
			cnt = 2'd1;
		end else if (rs >= ce) begin
			cnt = 2'd1;
			a_s = rs + d;
		end else if (cfg.strategy == rfar_pkg::STRAT_REMOVE) begin
			cnt = 2'd0;
		end else if (cfg.strategy == rfar_pkg::STRAT_RESIZE) begin
			priority if (rs >= cs && re <= ce) begin
				cnt = 2'd0;
			end else if (rs <= cs && re >= ce) begin
				// exact match drops, otherwise grow or shrink by the delta
				cnt = (rs == cs && re == ce) ? 2'd0 : 2'd1;
				a_l = rl + d;
			end else if (rs <= cs && cs <= re) begin
				cnt = 2'd1;
				if (d[AW-1]) begin
					a_l = cs - rs;
				end
			end else if (rs <= ce && ce <= re) begin
				cnt = 2'd1;
				if (d[AW-1]) begin
					a_s = ce + d;
					a_l = re - ce;
				end
			end else begin
				cnt = 2'd0;
			end
		end else begin
			cnt = {1'b0, has_left} + {1'b0, has_right};
			if (has_left) begin
				a_l = is_pos - rs;
			end else begin
				// right part alone moves to the first slot
				a_s = ie_pos + d;
				a_l = re - ie_pos;
			end
		end
	end

	assign sa_s = rfar_pkg::sat_pos(a_s, PosMax);
	assign sa_l = rfar_pkg::sat_pos(a_l, PosMax);
	assign sb_s = rfar_pkg::sat_pos(b_s, PosMax);
	assign sb_l = rfar_pkg::sat_pos(b_l, PosMax);

	always_comb begin
		fix.count         = cnt;
		fix.first.start   = sa_s[31:0];
		fix.first.length  = sa_l[31:0];
		fix.first.to_new  = 1'b0;
		fix.first.ovf     = sa_s[32] | sa_l[32];
		fix.second.start  = sb_s[31:0];
		fix.second.length = sb_l[31:0];
		fix.second.to_new = b_new;
		fix.second.ovf    = sb_s[32] | sb_l[32];
	end

endmodule

`default_nettype wire

/* hdl/region_fix_after_replace.sv */
// Top level: interval rewrite after a span replacement.
//
// Usage:
//   cfg    - register writes (index 0 cut_start, 1 cut_length, 2 insert_length,
//            3 strategy); always ready, write only while the block is idle.
//   region - one interval (region_start, region_length) per transaction.
//   result - zero, one or two intervals per input interval; last_of_run marks
//            the final one, overflow flags a saturated position or length.
// Pipeline: an input transaction goes through the input register, then the
//   result register.
// Throughput: one interval per cycle while result.ready is high; an interval
//   that splits into two parts holds the result register until both parts are
//   taken; an empty rewrite does not occupy the result register.
// Reset: arst_n clears both pipeline stages and sets cut_start, cut_length and
//   insert_length to 0 and strategy to resize.
// Stall: while result.ready is low the result register holds and the input
//   register fills; region.ready drops once both are occupied.
`timescale 1ns / 1ps
`default_nettype none
`include "region_fix_after_replace_macros.svh"

module region_fix_after_replace #(
	parameter int POS_WIDTH = 32
) (
	input  var logic   clk,
	input  var logic   arst_n,
	rfar_cfg_if.sink   cfg,
	rfar_in_if.sink    region,
	rfar_out_if.source result
);

	localparam int VW = (POS_WIDTH < 32) ? POS_WIDTH : 32;
	localparam logic [32:0] PosMax = (33'd1 << VW) - 33'd1;
	localparam logic [31:0] PosMask = PosMax[31:0];

	rfar_pkg::cfg_t     cfg_q;
	rfar_pkg::fix_out_t fix;

	logic        s1_valid_q;
	logic [31:0] rs_s1, rl_s1;
	logic        s2_valid_q, s2_two_q, s2_sel_q;
	rfar_pkg::res_t r0_s2, r1_s2, cur;
	logic        s2_done, s1_adv, in_acc;

	// Configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cut_start     <= '0;
			cfg_q.cut_length    <= '0;
			cfg_q.insert_length <= '0;
			cfg_q.strategy      <= rfar_pkg::STRAT_RESIZE;
		end else if (cfg.valid) begin
			unique case (rfar_pkg::reg_index_t'(cfg.index))
				rfar_pkg::REG_CUT_START:     cfg_q.cut_start     <= cfg.data & PosMask;
				rfar_pkg::REG_CUT_LENGTH:    cfg_q.cut_length    <= cfg.data & PosMask;
				rfar_pkg::REG_INSERT_LENGTH: cfg_q.insert_length <= cfg.data & PosMask;
				rfar_pkg::REG_STRATEGY:
					cfg_q.strategy <= rfar_pkg::strategy_t'(cfg.data[1:0]);
				default: ;
			endcase
		end
	end

	// Handshake control
	assign s2_done      = s2_valid_q && result.ready && (!s2_two_q || s2_sel_q);
	assign s1_adv       = s1_valid_q && (!s2_valid_q || s2_done);
	assign region.ready = !s1_valid_q || s1_adv;
	assign in_acc       = region.valid && region.ready;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_acc) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			rs_s1 <= region.region_start & PosMask;
			rl_s1 <= region.region_length & PosMask;
		end
	end

	rfar_fix #(
		.POS_WIDTH(POS_WIDTH)
	) u_fix (
		.cfg   (cfg_q),
		.rs_in (rs_s1),
		.rl_in (rl_s1),
		.fix   (fix)
	);

	// Result register; an empty rewrite leaves it free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
			s2_two_q   <= 1'b0;
			s2_sel_q   <= 1'b0;
		end else if (s1_adv) begin
			s2_valid_q <= fix.count != 2'd0;
			s2_two_q   <= fix.count == 2'd2;
			s2_sel_q   <= 1'b0;
		end else if (s2_done) begin
			s2_valid_q <= 1'b0;
			s2_sel_q   <= 1'b0;
		end else if (s2_valid_q && result.ready) begin
			// first of two parts taken: advance to the right part
			s2_sel_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			r0_s2 <= fix.first;
			r1_s2 <= fix.second;
		end
	end

	assign cur                      = s2_sel_q ? r1_s2 : r0_s2;
	assign result.valid             = s2_valid_q;
	assign result.out_start         = cur.start;
	assign result.out_length        = cur.length;
	assign result.to_new_annotation = cur.to_new;
	assign result.overflow          = cur.ovf;
	assign result.last_of_run       = !s2_two_q || s2_sel_q;

	`RFAR_ASSERT_IMP(a_sel_needs_pair, s2_sel_q, s2_valid_q && s2_two_q)
	`RFAR_ASSERT_IMP(a_no_overwrite_s1, in_acc && s1_valid_q, s1_adv)
	`RFAR_ASSERT_NXT(a_second_follows, result.valid && result.ready && !result.last_of_run,
		result.valid && s2_sel_q)
	`RFAR_ASSERT_IMP(a_new_only_second, result.valid && result.to_new_annotation, s2_sel_q)

endmodule

`default_nettype wire
